@@ src/sgcc_pkg.sv @@
// shared constants, payload types and control structs for the combination coefficient block
package sgcc_pkg;

    // index shape
    localparam int MAX_DIMS  = 8;
    localparam int IDX_W     = 4;
    localparam int LV_W      = IDX_W + 1;          // index plus offset bit, up to 16

    // configuration register widths
    localparam int DIMS_W    = 4;
    localparam int LEVEL_W   = 5;
    localparam int MODE_W    = 2;
    localparam int TW_W      = 8;

    // lanes and offset enumeration
    localparam int LANE_BITS = 3;
    localparam int NUM_LANES = 1 << LANE_BITS;
    localparam int Z_W       = MAX_DIMS;
    localparam int BATCH_W   = Z_W - LANE_BITS;
    localparam int LANE_LAT  = 2;

    // datapath widths
    localparam int SUMK_W    = 8;                  // sum of one-based levels, at most 8 * 17
    // sum of 2^(lv+1), at most 8 * 2^17
    localparam int POW_W     = (1 << IDX_W) + 2 + $clog2(MAX_DIMS);
    localparam int BOUND_W   = 32;                 // 2^level + 2(n-1), level up to 31
    localparam int RHS_W     = 6;                  // n + level - 1
    localparam int PROD_W    = TW_W + LV_W;        // weight times level
    localparam int CMP3_W    = PROD_W + 1;
    localparam int COEFF_W   = 10;
    localparam int BSUM_W    = LANE_BITS + 2;      // signed per-batch sum

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRADEOFF = 3'd3;

    localparam logic [MODE_W-1:0] MODE_EXP      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIMPLEX  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TENSOR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef idx_t [MAX_DIMS-1:0] idx_vec_t;

    typedef struct packed {
        idx_t level_index_0;
        idx_t level_index_1;
        idx_t level_index_2;
        idx_t level_index_3;
        idx_t level_index_4;
        idx_t level_index_5;
        idx_t level_index_6;
        idx_t level_index_7;
    } in_item_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] combination_coeff;
        logic                      base_member;
    } out_item_t;

    // per-item set rule, precomputed from the registers
    typedef struct packed {
        logic [MODE_W-1:0]  set_mode;
        logic [LEVEL_W-1:0] level;
        logic [MAX_DIMS-1:0] used;
        logic [BOUND_W-1:0] exp_bound;
        logic [RHS_W-1:0]   sum_bound;
        logic [TW_W-1:0]    weight;
        logic [PROD_W-1:0]  weight_level;
    } rule_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } issue_t;

    typedef struct packed {
        logic valid;
        logic member;
        logic odd;
    } lane_res_t;

endpackage

@@ src/sgcc_lane.sv @@
// one membership lane: tests a single offset vector against the set rule in two stages
module sgcc_lane import sgcc_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            issue_valid,
    input  logic [Z_W-1:0]  offset,
    input  idx_vec_t        base,
    input  rule_t           rule,
    output lane_res_t       res
);

    logic                a_valid_reg;
    logic                a_odd_reg;
    logic [SUMK_W-1:0]   sumk_reg;
    logic [SUMK_W-1:0]   sumk_next;
    logic [POW_W-1:0]    pow_reg;
    logic [POW_W-1:0]    pow_next;
    logic                fit_reg;
    logic                fit_next;
    logic [LV_W-1:0]     max_reg;
    logic [LV_W-1:0]     max_next;

    logic                member_next;
    logic [CMP3_W-1:0]   lhs3;
    logic [CMP3_W-1:0]   rhs3;
    logic                res_valid_reg;
    logic                res_member_reg;
    logic                res_odd_reg;

    // stage a: per-component sums, max and tensor fit
    always_comb
    begin
        logic [LV_W-1:0] lv;
        sumk_next = '0;
        pow_next  = '0;
        fit_next  = 1'b1;
        max_next  = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            lv = {1'b0, base[i]} + LV_W'(offset[i]);
            if (rule.used[i])
            begin
                sumk_next = sumk_next + SUMK_W'(lv) + SUMK_W'(1);
                pow_next  = pow_next + (POW_W'(1) << (lv + LV_W'(1)));
                if (LEVEL_W'(lv) >= rule.level)
                begin
                    fit_next = 1'b0;
                end
                if (lv > max_next)
                begin
                    max_next = lv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_odd_reg <= ^offset;
        sumk_reg  <= sumk_next;
        pow_reg   <= pow_next;
        fit_reg   <= fit_next;
        max_reg   <= max_next;
    end

    // stage b: apply the selected rule
    assign lhs3 = CMP3_W'(rule.weight) * CMP3_W'(max_reg) + CMP3_W'(rule.sum_bound);
    assign rhs3 = CMP3_W'(sumk_reg) + CMP3_W'(rule.weight_level);

    always_comb
    begin
        case (rule.set_mode)
            MODE_EXP:      member_next = BOUND_W'(pow_reg) <= rule.exp_bound;
            MODE_SIMPLEX:  member_next = sumk_reg <= SUMK_W'(rule.sum_bound);
            MODE_TENSOR:   member_next = fit_reg;
            MODE_WEIGHTED: member_next = lhs3 >= rhs3;
            default:       member_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_member_reg <= member_next;
        res_odd_reg    <= a_odd_reg;
    end

    assign res = {res_valid_reg, res_member_reg, res_odd_reg};

endmodule

@@ src/sgcc_merge.sv @@
// merging stage: signed sum of lane hits into the coefficient accumulator
module sgcc_merge import sgcc_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  issue_t                     issue,
    input  lane_res_t [NUM_LANES-1:0]  lanes,
    input  logic                       take,
    output logic                       done,
    output out_item_t                  result
);

    issue_t                     tag_reg [LANE_LAT];
    issue_t                     aligned;
    logic signed [BSUM_W-1:0]   bsum;
    logic signed [COEFF_W-1:0]  acc_reg;
    logic signed [COEFF_W-1:0]  acc_next;
    logic                       member_reg;
    logic                       done_reg;
    logic [NUM_LANES-1:0]       lane_valid;

    // batch tags follow the lane pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANE_LAT; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= issue;
            for (int k = 1; k < LANE_LAT; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign aligned = tag_reg[LANE_LAT-1];

    always_comb
    begin
        bsum = '0;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            lane_valid[j] = lanes[j].valid;
            if (lanes[j].valid && lanes[j].member)
            begin
                bsum = lanes[j].odd ? bsum - BSUM_W'(1) : bsum + BSUM_W'(1);
            end
        end
    end

    assign acc_next = (aligned.first ? '0 : acc_reg) + COEFF_W'(bsum);

    always_ff @(posedge clk)
    begin
        if (aligned.valid)
        begin
            acc_reg <= acc_next;
        end
        if (aligned.valid && aligned.first)
        begin
            member_reg <= lanes[0].member;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (take)
        begin
            done_reg <= 1'b0;
        end
        else if (aligned.valid && aligned.last)
        begin
            done_reg <= 1'b1;
        end
    end

    assign done                     = done_reg;
    assign result.combination_coeff = acc_reg;
    assign result.base_member       = member_reg;

`ifndef SYNTH
    // lane 0 holds the lowest offset, so it is live whenever any lane is
    a_lane0_live: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_valid) |-> lanes[0].valid)
        else $error("lane hit without lane 0");

    a_tag_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        aligned.valid == lanes[0].valid)
        else $error("batch tag out of step with lane results");

    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> done_reg)
        else $error("result taken before accumulation finished");
`endif

endmodule

@@ src/sparse_grid_combination_coeff.sv @@
// top level: registers, offset sequencer, lane array, merge and output register
//
// sparse-grid combination coefficient unit
// in channel (in_valid/in_ready/in_item): one multi-index of eight 4-bit levels;
//   only the first dims_in_use components take part
// out channel (out_valid/out_ready/out_item): signed coefficient and the flag
//   telling whether the index itself is in the set
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; writes to indexes past the last register are dropped
// the 2^n offset vectors are split into batches of eight, one batch per cycle,
//   each offset tested in its own lane; the merge stage sums the +1/-1 hits
// an accepted item runs its batches through the lane stages into the merge
//   accumulator; once the last batch is in, the sum moves into the output register
// the input is taken only when no item is in flight; a finished result moves
//   into the output register, so the next item can start while it waits
// a stalled receiver holds the output register; a following result then waits
//   in the merge stage until the register frees up
// reset clears the control state and loads the register defaults
//   (dims 1, level 1, simplex mode, weight 0)
module sparse_grid_combination_coeff import sgcc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    // configuration registers
    logic [DIMS_W-1:0]   dims_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [TW_W-1:0]     weight_reg;

    // sequencer
    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [BATCH_W-1:0]  batch_reg;
    logic [BATCH_W-1:0]  batch_next;
    logic [BATCH_W-1:0]  last_batch_reg;

    // per-item context
    idx_vec_t            base_reg;
    idx_vec_t            base_next;
    rule_t               rule_reg;
    rule_t               rule_next;
    logic [DIMS_W-1:0]   n_eff;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_item_reg;

    logic                accept;
    logic                take;
    logic                merge_done;
    out_item_t           merge_result;
    issue_t              issue;
    lane_res_t [NUM_LANES-1:0] lane_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg   <= DIMS_W'(1);
            level_reg  <= LEVEL_W'(1);
            mode_reg   <= MODE_SIMPLEX;
            weight_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIMS:     dims_reg   <= cfg_data[DIMS_W-1:0];
                REG_LEVEL:    level_reg  <= cfg_data[LEVEL_W-1:0];
                REG_MODE:     mode_reg   <= cfg_data[MODE_W-1:0];
                REG_TRADEOFF: weight_reg <= cfg_data[TW_W-1:0];
                default:      ;
            endcase
        end
    end

    // zero dims counts as one, anything past the maximum saturates
    always_comb
    begin
        if (dims_reg == '0)
        begin
            n_eff = DIMS_W'(1);
        end
        else if (dims_reg > DIMS_W'(MAX_DIMS))
        begin
            n_eff = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            n_eff = dims_reg;
        end
    end

    // rule constants for the item; the used mask doubles as the highest offset
    always_comb
    begin
        rule_next.set_mode = mode_reg;
        rule_next.level    = level_reg;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            rule_next.used[i] = DIMS_W'(i) < n_eff;
        end
        rule_next.exp_bound    = (BOUND_W'(1) << level_reg)
                               + ((BOUND_W'(n_eff) - BOUND_W'(1)) << 1);
        rule_next.sum_bound    = RHS_W'(level_reg) + RHS_W'(n_eff) - RHS_W'(1);
        rule_next.weight       = weight_reg;
        rule_next.weight_level = PROD_W'(weight_reg) * PROD_W'(level_reg);
    end

    always_comb
    begin
        base_next[0] = in_item.level_index_0;
        base_next[1] = in_item.level_index_1;
        base_next[2] = in_item.level_index_2;
        base_next[3] = in_item.level_index_3;
        base_next[4] = in_item.level_index_4;
        base_next[5] = in_item.level_index_5;
        base_next[6] = in_item.level_index_6;
        base_next[7] = in_item.level_index_7;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg       <= base_next;
            rule_reg       <= rule_next;
            last_batch_reg <= rule_next.used[Z_W-1:LANE_BITS];
        end
    end

    // one batch of offsets per cycle while running
    assign issue.valid = (state_reg == ST_RUN);
    assign issue.first = (batch_reg == '0);
    assign issue.last  = (batch_reg == last_batch_reg);

    assign take = (state_reg == ST_WAIT) && merge_done && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        batch_next = batch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    batch_next = '0;
                end
            end
            ST_RUN:
            begin
                if (issue.last)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    batch_next = batch_reg + BATCH_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            batch_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            batch_reg <= batch_next;
        end
    end

    // lane array: lane g tests offset {batch, g} if it lies below 2^n
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        logic [Z_W-1:0] offset;
        logic           live;

        assign offset = {batch_reg, LANE_BITS'(g)};
        assign live   = issue.valid && (offset <= rule_reg.used);

        sgcc_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .issue_valid (live),
            .offset      (offset),
            .base        (base_reg),
            .rule        (rule_reg),
            .res         (lane_res[g])
        );
    end

    sgcc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .lanes  (lane_res),
        .take   (take),
        .done   (merge_done),
        .result (merge_result)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= merge_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && (batch_reg == '0))
        else $error("accepted item did not start at the first batch");

    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (batch_reg <= last_batch_reg))
        else $error("batch counter ran past the last batch");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        merge_done |-> (state_reg == ST_WAIT))
        else $error("merge finished outside the wait state");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result hand-off did not load the output register");
`endif

endmodule
